// ===== rtl/c3zp_pkg.sv =====
// Shared types and constants for the 3x3 zero-padded convolution block.
`timescale 1ns / 1ps
`default_nettype none

package c3zp_pkg;

  // Fixed field widths.
  localparam int PIX_W     = 16;
  localparam int RES_W     = 24;
  localparam int DIM_W     = 11;
  localparam int COEF_W    = 16;
  localparam int KROW_W    = 48;
  localparam int FRAC_BITS = 12;
  localparam int TAPS      = 9;
  localparam int SIDE      = 3;

  // Largest frame height; the row counter saturates well above it.
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 12;

  // Line buffer entry: the row two above in the upper half, one above in the lower.
  localparam int LB_W = 2 * PIX_W;

  // Products, row sums and the full sum.
  localparam int PROD_W = 2 * PIX_W;
  localparam int RSUM_W = PROD_W + 2;
  localparam int SUM_W  = RSUM_W + 2;

  // Job queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT   = 3'd4;

  // Identity kernel row: 1.0 in Q4.12 at the middle coefficient.
  localparam logic [KROW_W-1:0] KERNEL_MID_RST = 48'h0000_1000_0000;

  // Kernel rows, row k at index k, coefficient c at bits 16c.
  typedef logic [SIDE-1:0][KROW_W-1:0] c3zp_kernel_t;

  // One output job: the masked 3x3 window and the end-of-frame flag.
  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] taps;
    logic                       last;
  } c3zp_job_t;

endpackage

`default_nettype wire

// ===== rtl/c3zp_in_if.sv =====
// Pixel input channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface c3zp_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [16-1:0]     pixel_value;
  logic                     is_padding;

  modport source (output valid, output pixel_value, output is_padding, input ready);
  modport sink (input valid, input pixel_value, input is_padding, output ready);
endinterface

`default_nettype wire

// ===== rtl/c3zp_out_if.sv =====
// Filtered result channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface c3zp_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [24-1:0] filtered_value;
  logic                 end_of_frame;

  modport source (output valid, output filtered_value, output end_of_frame, input ready);
  modport sink (input valid, input filtered_value, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/c3zp_cfg_if.sv =====
// Configuration write channel interface.
`timescale 1ns / 1ps
`default_nettype none

interface c3zp_cfg_if;
  logic          valid;
  logic          ready;
  logic [3-1:0]  index;
  logic [48-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/c3zp_cfg.sv =====
// Configuration registers with frame size clamping and frame area.
`timescale 1ns / 1ps
`default_nettype none

module c3zp_cfg
  import c3zp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int AW = WW + DIM_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  c3zp_cfg_if.sink              cfg_ch,
  output logic [WW-1:0]         frame_w,
  output logic [DIM_W-1:0]      frame_h,
  output logic [AW-1:0]         frame_area,
  output c3zp_kernel_t          kernel
);

  localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [WW-1:0]    width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [AW-1:0]    area_r;
  c3zp_kernel_t     kernel_r;
  logic [DIM_W-1:0] wd;
  logic [WW-1:0]    w_cl;
  logic [DIM_W-1:0] h_cl;
  logic             wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;
  assign wd = cfg_ch.wdata[DIM_W-1:0];

  always_comb begin
    if (wd == '0) begin
      w_cl = WW'(1);
    end else if ((WW + DIM_W)'(wd) > (WW + DIM_W)'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(wd);
    end
    if (wd == '0) begin
      h_cl = DIM_W'(1);
    end else if (wd > DIM_W'(MAX_HEIGHT)) begin
      h_cl = DIM_W'(MAX_HEIGHT);
    end else begin
      h_cl = wd;
    end
  end

  // The area follows whichever dimension is being written.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr && cfg_ch.index == CFG_FRAME_WIDTH) begin
      width_nxt = w_cl;
    end
    if (wr && cfg_ch.index == CFG_FRAME_HEIGHT) begin
      height_nxt = h_cl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RST_W);
      height_r <= DIM_W'(MAX_HEIGHT);
      area_r   <= AW'(RST_W * MAX_HEIGHT);
      kernel_r <= {48'h0, KERNEL_MID_RST, 48'h0};
    end else if (wr) begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      area_r   <= AW'(width_nxt) * AW'(height_nxt);
      case (cfg_ch.index)
        CFG_KERNEL_TOP: kernel_r[0] <= cfg_ch.wdata;
        CFG_KERNEL_MID: kernel_r[1] <= cfg_ch.wdata;
        CFG_KERNEL_BOT: kernel_r[2] <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  assign frame_w    = width_r;
  assign frame_h    = height_r;
  assign frame_area = area_r;
  assign kernel     = kernel_r;

endmodule

`default_nettype wire

// ===== rtl/c3zp_queue.sv =====
// Small job queue that decouples the window front from the multiply back.
`timescale 1ns / 1ps
`default_nettype none

module c3zp_queue
  import c3zp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire c3zp_job_t     push_job,
  output logic [Q_CNT_W-1:0] count,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output c3zp_job_t          pop_job
);

  c3zp_job_t          q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_job   = q_mem[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < Q_CNT_W'(Q_DEPTH)) || pop)
    else $error("job queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("job queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/c3zp_front.sv =====
// Front: input acceptance, stream position, line buffers, window and border masks.
`timescale 1ns / 1ps
`default_nettype none

module c3zp_front
  import c3zp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int AW = WW + DIM_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  c3zp_in_if.sink            in_ch,
  input  wire logic [WW-1:0] frame_w,
  input  wire logic [DIM_W-1:0] frame_h,
  input  wire logic [AW-1:0] frame_area,
  input  wire logic [Q_CNT_W-1:0] q_count,
  output logic               q_push,
  output c3zp_job_t          q_job
);

  // Classification of one accepted item.
  typedef struct packed {
    logic produce;
    logic last;
    logic x_first;
    logic x_end;
    logic y_first;
    logic y_end;
  } cls_t;

  // Line buffer memory and its clearing sweep.
  logic [LB_W-1:0] lbuf [MAX_WIDTH];
  logic [LB_W-1:0] rd_q;
  logic            clearing_r;
  logic [CW-1:0]   clr_addr_r;

  // Stream position.
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic [AW-1:0]    count_r;

  logic             in_acc;
  logic [PIX_W-1:0] pix;
  logic [WW-1:0]    col_p1;
  logic             wrap;
  logic [ROW_W-1:0] row_inc;
  logic [AW:0]      count_p1;
  cls_t             cls;

  // Window stage.
  logic             s1_valid_r;
  logic [CW-1:0]    s1_col_r;
  logic [PIX_W-1:0] s1_pix_r;
  cls_t             s1_cls_r;
  logic [TAPS-1:0][PIX_W-1:0] win_r, win_nxt;

  // Forwarding of the write made at the edge that issued the current read.
  logic             byp_valid_r;
  logic [CW-1:0]    byp_col_r;
  logic [LB_W-1:0]  byp_data_r;

  logic [LB_W-1:0]  rd_eff;
  logic [PIX_W-1:0] up_pix, lo_pix;
  logic             wr_en;
  logic [CW-1:0]    wr_addr;
  logic [LB_W-1:0]  wr_data;
  logic             room;

  assign room        = ({1'b0, q_count} + {{Q_CNT_W{1'b0}}, s1_valid_r}) <
                       (Q_CNT_W + 1)'(Q_DEPTH);
  assign in_ch.ready = !clearing_r && room;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pix         = in_ch.is_padding ? '0 : in_ch.pixel_value;

  always_comb begin
    col_p1   = WW'(col_r) + WW'(1);
    wrap     = (col_p1 >= frame_w);
    row_inc  = (row_r == '1) ? row_r : row_r + ROW_W'(1);
    count_p1 = (AW + 1)'(count_r) + (AW + 1)'(1);

    cls.produce = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    cls.last    = cls.produce && (count_p1 >= (AW + 1)'(frame_area));
    cls.x_first = (col_r == CW'(1)) || ((col_r == '0) && (frame_w == WW'(1)));
    cls.x_end   = (col_r == '0) || (WW'(col_r) >= frame_w);
    if (col_r != '0) begin
      cls.y_first = (row_r == ROW_W'(1));
      cls.y_end   = (row_r >= ROW_W'(frame_h));
    end else begin
      cls.y_first = (row_r == ROW_W'(2));
      cls.y_end   = (row_r >= ROW_W'(frame_h) + ROW_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      count_r <= '0;
    end else if (in_acc) begin
      if (cls.last) begin
        col_r   <= '0;
        row_r   <= '0;
        count_r <= '0;
      end else begin
        col_r <= wrap ? '0 : col_p1[CW-1:0];
        row_r <= wrap ? row_inc : row_r;
        if (cls.produce) begin
          count_r <= count_p1[AW-1:0];
        end
      end
    end
  end

  // Clearing sweep after reset, one entry a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + CW'(1);
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_comb begin
    rd_eff  = (byp_valid_r && (byp_col_r == s1_col_r)) ? byp_data_r : rd_q;
    up_pix  = rd_eff[LB_W-1:PIX_W];
    lo_pix  = rd_eff[PIX_W-1:0];
    wr_en   = clearing_r || s1_valid_r;
    wr_addr = clearing_r ? clr_addr_r : s1_col_r;
    wr_data = clearing_r ? '0 : {lo_pix, s1_pix_r};
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q <= lbuf[col_r];
    end
    if (wr_en) begin
      lbuf[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_acc;
      byp_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= col_r;
      s1_pix_r <= pix;
      s1_cls_r <= cls;
    end
    byp_col_r  <= s1_col_r;
    byp_data_r <= {lo_pix, s1_pix_r};
  end

  // Window shifts left; the new column comes from the buffers and the pixel.
  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up_pix;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = lo_pix;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // Taps that fall outside the frame are zeroed before the job is queued.
  always_comb begin
    q_job.last = s1_cls_r.last;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if ((r == 0 && s1_cls_r.y_first) || (r == SIDE - 1 && s1_cls_r.y_end) ||
            (c == 0 && s1_cls_r.x_first) || (c == SIDE - 1 && s1_cls_r.x_end)) begin
          q_job.taps[r * SIDE + c] = '0;
        end else begin
          q_job.taps[r * SIDE + c] = win_nxt[r * SIDE + c];
        end
      end
    end
  end

  assign q_push = s1_valid_r && s1_cls_r.produce;

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && cls.last |=> (col_r == '0) && (row_r == '0) && (count_r == '0))
    else $error("stream position not cleared after the last output of a frame");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r && !q_push)
    else $error("item in flight during the line buffer clearing sweep");

endmodule

`default_nettype wire

// ===== rtl/c3zp_back.sv =====
// Back: nine multiplies, row sums, final sum with floor shift, output register.
`timescale 1ns / 1ps
`default_nettype none

module c3zp_back
  import c3zp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire c3zp_kernel_t kernel,
  input  wire logic job_valid,
  output logic      job_ready,
  input  wire c3zp_job_t job,
  c3zp_out_if.source out_ch
);

  logic                     p_valid_r;
  logic                     p_last_r;
  logic signed [PROD_W-1:0] prod_r   [TAPS];
  logic signed [PROD_W-1:0] prod_nxt [TAPS];

  logic                     r_valid_r;
  logic                     r_last_r;
  logic signed [RSUM_W-1:0] rsum_r   [SIDE];
  logic signed [RSUM_W-1:0] rsum_nxt [SIDE];

  logic                     o_valid_r;
  logic                     o_last_r;
  logic [RES_W-1:0]         o_data_r;
  logic signed [SUM_W-1:0]  sum;

  logic o_ready, r_ready, p_ready;

  assign o_ready   = !o_valid_r || out_ch.ready;
  assign r_ready   = !r_valid_r || o_ready;
  assign p_ready   = !p_valid_r || r_ready;
  assign job_ready = p_ready;

  // Window tap (r, c) meets kernel coefficient (2-r, 2-c): the kernel is flipped.
  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        prod_nxt[r * SIDE + c] =
          $signed(kernel[SIDE - 1 - r][COEF_W * (SIDE - 1 - c) +: COEF_W]) *
          $signed(job.taps[r * SIDE + c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      rsum_nxt[r] = RSUM_W'(prod_r[r * SIDE]) + RSUM_W'(prod_r[r * SIDE + 1]) +
                    RSUM_W'(prod_r[r * SIDE + 2]);
    end
    sum = SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_r <= job_valid;
      end
      if (r_ready) begin
        r_valid_r <= p_valid_r;
      end
      if (o_ready) begin
        o_valid_r <= r_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && job_valid) begin
      prod_r   <= prod_nxt;
      p_last_r <= job.last;
    end
    if (r_ready && p_valid_r) begin
      rsum_r   <= rsum_nxt;
      r_last_r <= p_last_r;
    end
    if (o_ready && r_valid_r) begin
      o_data_r <= sum[FRAC_BITS +: RES_W];
      o_last_r <= r_last_r;
    end
  end

  assign out_ch.valid          = o_valid_r;
  assign out_ch.filtered_value = o_data_r;
  assign out_ch.end_of_frame   = o_last_r;

endmodule

`default_nettype wire

// ===== rtl/conv3x3_zero_pad.sv =====
// Top level of the streaming 3x3 convolution with zero padding.
`timescale 1ns / 1ps
`default_nettype none

// This block takes signed 16-bit pixels in raster order, one transaction per
// pixel, and returns the true 3x3 convolution (kernel flipped in both axes) of
// the frame with zero padding at every border. The result for pixel (x,y) comes
// out after pixel (x+1,y+1) has been taken, so after the frame the source sends
// width+1 padding transactions to flush the last results; end_of_frame marks
// the final result, after which the next transaction starts a new frame. The
// block sustains one pixel per clock while the job queue has room and the
// clearing sweep is over: a front stage reads the two line buffers (one read
// and one write port, with forwarding so a one-pixel-wide frame still runs at
// full rate), builds the window and zeroes taps outside the frame; a
// four-entry job queue then feeds a back end of nine parallel 16x16
// multiplies, a row-sum stage and a final sum that feeds the output register.
// A result passes the front stage register, the job queue and the
// product, row-sum and output registers, and the queue lets the input side
// keep going for a few transactions while the output is stalled. Results are
// the sum of Q4.12 products shifted right by 12 with rounding toward minus
// infinity. After reset the line buffers are cleared in a sweep over all
// MAX_WIDTH entries during which no pixel is taken; configuration writes are
// taken at any time and must only be issued while no result is outstanding.
// Frame width and height are clamped to 1..MAX_WIDTH and 1..1024.
module conv3x3_zero_pad
  import c3zp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  c3zp_in_if.sink     in_ch,
  c3zp_out_if.source  out_ch,
  c3zp_cfg_if.sink    cfg_ch
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = WW + DIM_W;

  logic [WW-1:0]      frame_w;
  logic [DIM_W-1:0]   frame_h;
  logic [AW-1:0]      frame_area;
  c3zp_kernel_t       kernel;

  logic [Q_CNT_W-1:0] q_count;
  logic               q_push;
  c3zp_job_t          q_push_job;
  logic               q_pop_valid;
  logic               q_pop_ready;
  c3zp_job_t          q_pop_job;

  // Configuration registers, clamped frame size and frame area.
  c3zp_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .frame_w    (frame_w),
    .frame_h    (frame_h),
    .frame_area (frame_area),
    .kernel     (kernel)
  );

  // Front: stream position, line buffers, window and border masking.
  c3zp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .frame_w    (frame_w),
    .frame_h    (frame_h),
    .frame_area (frame_area),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_job      (q_push_job)
  );

  // Jobs wait here so the front and the back can stall independently.
  c3zp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .count     (q_count),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_job   (q_pop_job)
  );

  // Back: multiply-accumulate and output register.
  c3zp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .kernel    (kernel),
    .job_valid (q_pop_valid),
    .job_ready (q_pop_ready),
    .job       (q_pop_job),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the streaming 3x3 zero-padded convolution block.
`timescale 1ns / 1ps

// The bench drives raster-order pixel transactions into the block, predicts
// every filtered result with its own bit-exact model of the line buffers,
// window and masking, and compares each result transaction against the oldest
// pending prediction. A short directed table comes first: one-pixel frames,
// clamped dimensions, extreme coefficients, padding inside a frame, a real
// pixel during the flush and a width change in the middle of a frame. Then
// random phases of small frames with random kernels follow. Both sides insert
// random gaps, and one phase holds the result side off for a long stretch so
// the block fills up.
module testbench;
  import c3zp_pkg::*;

  localparam int MAX_W = 1024;
  // Cycles to let pass after the last pending result before a register
  // write, so that no transaction is still in flight in the block.
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT = 1_000_000;

  // Register indexes the block does not implement; writes to them must be
  // harmless.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_C = 3'd7;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    frame_end;
  } pixel_result_t;

  // One row of the directed table: a register write, a pixel transaction
  // (optionally with its result written out by hand) or a flush to the end
  // of the current frame.
  typedef enum logic [1:0] {STEP_CFG, STEP_PIX, STEP_FLUSH} plan_kind_e;

  typedef struct packed {
    plan_kind_e              kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [KROW_W-1:0]       reg_data;
    logic signed [PIX_W-1:0] pix;
    logic                    pad;
    logic                    known;
    pixel_result_t           want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  c3zp_in_if  in_ch ();
  c3zp_out_if out_ch ();
  c3zp_cfg_if cfg_ch ();

  conv3x3_zero_pad #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor copy of the configuration registers.
  logic [DIM_W-1:0]  cfg_width;
  logic [DIM_W-1:0]  cfg_height;
  logic [KROW_W-1:0] kernel_rows [SIDE];

  // Predictor copy of the block state: the rows two and one above, the
  // window, and the stream position.
  logic signed [PIX_W-1:0] upper_line [MAX_W];
  logic signed [PIX_W-1:0] lower_line [MAX_W];
  logic signed [PIX_W-1:0] window_taps [TAPS];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned results_in_frame;

  pixel_result_t pending_results[$];
  plan_row_t     directed_plan[$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned in_gap_max;
  int unsigned out_stall_max;
  bit          hold_output;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [COEF_W-1:0] kernel_coef(input int kr, input int kc);
    return kernel_rows[kr][COEF_W*kc +: COEF_W];
  endfunction

  // Advances the predicted state by one accepted pixel and returns the
  // result that this pixel releases, if any.
  function automatic void convolve_pixel(input logic signed [PIX_W-1:0] pix_in,
                                         input logic pad, output bit produced,
                                         output pixel_result_t res);
    int unsigned w, h, col, row, x, y;
    logic signed [PIX_W-1:0] pix;
    longint acc;
    int r, c;
    produced = 1'b0;
    res = '0;
    w = clamp_dim(cfg_width, MAX_W);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    pix = pad ? '0 : pix_in;
    col = col_pos % MAX_W;
    row = row_pos;

    // Shift the window one column left and bring in the new column.
    for (r = 0; r < SIDE; r++) begin
      window_taps[r*3]   = window_taps[r*3+1];
      window_taps[r*3+1] = window_taps[r*3+2];
    end
    window_taps[2] = upper_line[col];
    window_taps[5] = lower_line[col];
    window_taps[8] = pix;
    upper_line[col] = lower_line[col];
    lower_line[col] = pix;

    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end

    // The first result needs one full row plus one pixel of history.
    if (!(row >= 2 || (row == 1 && col >= 1))) return;

    // The window is centered on the pixel one row up and one column left.
    x = (col > 0) ? col - 1 : w - 1;
    y = (col > 0) ? row - 1 : row - 2;
    acc = 0;
    for (r = 0; r < SIDE; r++) begin
      for (c = 0; c < SIDE; c++) begin
        // Taps outside the frame count as zero; the kernel is flipped.
        if (!((r == 0 && y == 0) || (r == 2 && y + 1 >= h) ||
              (c == 0 && x == 0) || (c == 2 && x + 1 >= w))) begin
          acc += longint'(kernel_coef(2 - r, 2 - c)) * longint'(window_taps[r*3+c]);
        end
      end
    end
    acc = acc >>> FRAC_BITS;
    res.value = acc[RES_W-1:0];
    res.frame_end = (results_in_frame + 1 >= w * h);
    if (res.frame_end) begin
      results_in_frame = 0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      results_in_frame = results_in_frame + 1;
    end
    produced = 1'b1;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] rand_kernel_row();
    logic [KROW_W-1:0] row_bits;
    int c;
    row_bits = '0;
    case ($urandom_range(0, 5))
      0: row_bits = KERNEL_MID_RST;
      1: row_bits = 48'h8000_8000_8000;
      2: row_bits = 48'h7FFF_7FFF_7FFF;
      3: begin
        // Moderate coefficients between -2.0 and 2.0.
        for (c = 0; c < SIDE; c++) begin
          row_bits[COEF_W*c +: COEF_W] = 16'($urandom_range(0, 16'h4000)) - 16'h2000;
        end
      end
      default: row_bits = {16'($urandom()), 32'($urandom())};
    endcase
    return row_bits;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [KROW_W-1:0] data);
    return '{STEP_CFG, idx, data, '0, 1'b0, 1'b0, '0};
  endfunction

  function automatic plan_row_t pix_row(input logic signed [PIX_W-1:0] pix, input logic pad);
    return '{STEP_PIX, CFG_FRAME_WIDTH, '0, pix, pad, 1'b0, '0};
  endfunction

  function automatic plan_row_t known_row(input logic signed [PIX_W-1:0] pix, input logic pad,
                                          input logic signed [RES_W-1:0] v, input logic last);
    return '{STEP_PIX, CFG_FRAME_WIDTH, '0, pix, pad, 1'b1, '{v, last}};
  endfunction

  // Offers one pixel transaction after a random gap. When it is accepted the
  // predictor runs, and any released result is queued; a hand-written
  // result, where given, takes the place of the predicted one.
  task automatic send_item(input logic signed [PIX_W-1:0] pix, input logic pad,
                           input bit use_fixed = 1'b0,
                           input pixel_result_t fixed_res = '0);
    int unsigned gap;
    bit produced;
    pixel_result_t res;
    gap = $urandom_range(0, in_gap_max);
    cfg_ch.valid <= 1'b0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_value <= pix;
    in_ch.is_padding  <= pad;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    convolve_pixel(pix, pad, produced, res);
    if (use_fixed) begin
      produced = 1'b1;
      res = fixed_res;
    end
    if (produced) pending_results.push_back(res);
    items_sent++;
  endtask

  // Leaves cfg valid high on return; whoever acts next lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_FRAME_WIDTH:  cfg_width = data[DIM_W-1:0];
      CFG_FRAME_HEIGHT: cfg_height = data[DIM_W-1:0];
      CFG_KERNEL_TOP:   kernel_rows[0] = data;
      CFG_KERNEL_MID:   kernel_rows[1] = data;
      CFG_KERNEL_BOT:   kernel_rows[2] = data;
      default: ;
    endcase
  endtask

  // Waits until every predicted result has come out, then lets the
  // pipeline settle so that no transaction is still in flight.
  task automatic wait_drained();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
                           input logic [KROW_W-1:0] bot);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, KROW_W'(w));
    write_reg(CFG_FRAME_HEIGHT, KROW_W'(h));
    write_reg(CFG_KERNEL_TOP, top);
    write_reg(CFG_KERNEL_MID, mid);
    write_reg(CFG_KERNEL_BOT, bot);
  endtask

  // Sends padding until the predictor says the current frame has ended.
  task automatic flush_frame();
    while (col_pos != 0 || row_pos != 0 || results_in_frame != 0) begin
      send_item(rand_pixel(), 1'b1);
    end
  endtask

  // One frame plus its flush. A noisy frame sprinkles padding inside the
  // frame and real pixels inside the flush, and sometimes appends a few
  // stray transactions that start the next frame early.
  task automatic run_frame(input bit noisy);
    int unsigned w, h;
    w = clamp_dim(cfg_width, MAX_W);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    repeat (w * h) send_item(rand_pixel(), noisy && $urandom_range(0, 15) == 0);
    repeat (w + 1) send_item(rand_pixel(), !(noisy && $urandom_range(0, 15) == 0));
    if (noisy && $urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 5)) send_item(rand_pixel(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side: draws a stall before each transaction, or holds off for a
  // long stretch when asked, then checks what it accepts against the oldest
  // pending prediction.
  initial begin
    int unsigned stall;
    pixel_result_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_output) begin
        stall = LONG_HOLD;
        hold_output = 1'b0;
      end else begin
        stall = $urandom_range(0, out_stall_max);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: filtered_value %0d, end_of_frame %0b",
                                out_ch.filtered_value, out_ch.end_of_frame));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.filtered_value !== want.value) begin
          note_mismatch($sformatf("filtered_value mismatch: expected %0d, got %0d",
                                  $signed(want.value), out_ch.filtered_value));
        end
        if (out_ch.end_of_frame !== want.frame_end) begin
          note_mismatch($sformatf("end_of_frame mismatch: expected %0b, got %0b",
                                  want.frame_end, out_ch.end_of_frame));
        end
      end
    end
  end

  initial begin
    int unsigned random_base;
    int unsigned phase_idx;
    logic [DIM_W-1:0] w_pick;
    logic [DIM_W-1:0] h_pick;
    mismatch_count = 0;
    items_sent = 0;
    in_gap_max = 15;
    out_stall_max = 15;
    hold_output = 1'b0;

    // Predictor state matches the block right after reset.
    cfg_width = 11'd1024;
    cfg_height = 11'd1024;
    kernel_rows[0] = '0;
    kernel_rows[1] = KERNEL_MID_RST;
    kernel_rows[2] = '0;
    foreach (upper_line[i]) upper_line[i] = '0;
    foreach (lower_line[i]) lower_line[i] = '0;
    foreach (window_taps[i]) window_taps[i] = '0;
    col_pos = 0;
    row_pos = 0;
    results_in_frame = 0;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.pixel_value <= '0;
    in_ch.is_padding  <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_FRAME_WIDTH;
    cfg_ch.wdata      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // One-pixel frames: width and height written as zero clamp to one, and
    // the identity kernel from reset passes the pixel straight through.
    // Most padding transactions carry nonzero pixel bits that must be ignored.
    directed_plan.push_back(cfg_row(CFG_FRAME_WIDTH, 48'd0));
    directed_plan.push_back(cfg_row(CFG_FRAME_HEIGHT, 48'd0));
    directed_plan.push_back(pix_row(16'sh7FFF, 1'b0));
    directed_plan.push_back(pix_row(16'sh1234, 1'b1));
    directed_plan.push_back(known_row(16'shFFFF, 1'b1, 24'sd32767, 1'b1));
    directed_plan.push_back(pix_row(16'sh8000, 1'b0));
    directed_plan.push_back(pix_row(16'sh0000, 1'b1));
    directed_plan.push_back(known_row(16'sh7FFF, 1'b1, -24'sd32768, 1'b1));
    // Writes to unimplemented indexes must leave everything unchanged.
    directed_plan.push_back(cfg_row(CFG_SPARE_A, 48'hFFFF_FFFF_FFFF));
    directed_plan.push_back(cfg_row(CFG_SPARE_B, 48'hFFFF_FFFF_FFFF));
    directed_plan.push_back(cfg_row(CFG_SPARE_C, 48'hFFFF_FFFF_FFFF));
    // A 2x2 frame with every coefficient at -8.0 and the most negative
    // pixels, with padding inside the frame and a real pixel in the flush.
    directed_plan.push_back(cfg_row(CFG_FRAME_WIDTH, 48'd2));
    directed_plan.push_back(cfg_row(CFG_FRAME_HEIGHT, 48'd2));
    directed_plan.push_back(cfg_row(CFG_KERNEL_TOP, 48'h8000_8000_8000));
    directed_plan.push_back(cfg_row(CFG_KERNEL_MID, 48'h8000_8000_8000));
    directed_plan.push_back(cfg_row(CFG_KERNEL_BOT, 48'h8000_8000_8000));
    directed_plan.push_back(pix_row(16'sh8000, 1'b0));
    directed_plan.push_back(pix_row(16'sh7FFF, 1'b1));
    directed_plan.push_back(pix_row(16'sh8000, 1'b0));
    directed_plan.push_back(pix_row(16'sh8000, 1'b0));
    directed_plan.push_back(pix_row(16'sh0000, 1'b1));
    directed_plan.push_back(pix_row(16'sd12345, 1'b0));
    directed_plan.push_back(pix_row(16'sh0000, 1'b1));
    // Mixed extreme coefficients, then the width drops from three to two
    // in the middle of the frame; the column wraps at the new width.
    directed_plan.push_back(cfg_row(CFG_FRAME_WIDTH, 48'd3));
    directed_plan.push_back(cfg_row(CFG_KERNEL_TOP, 48'h7FFF_0000_8000));
    directed_plan.push_back(cfg_row(CFG_KERNEL_MID, 48'h0800_F000_1000));
    directed_plan.push_back(cfg_row(CFG_KERNEL_BOT, 48'h0001_FFFF_7FFE));
    directed_plan.push_back(pix_row(16'sh7FFF, 1'b0));
    directed_plan.push_back(pix_row(16'shFFFF, 1'b0));
    directed_plan.push_back(pix_row(16'sh0000, 1'b0));
    directed_plan.push_back(pix_row(16'sh0100, 1'b0));
    directed_plan.push_back(cfg_row(CFG_FRAME_WIDTH, 48'd2));
    directed_plan.push_back('{STEP_FLUSH, CFG_FRAME_WIDTH, '0, '0, 1'b0, 1'b0, '0});

    foreach (directed_plan[i]) begin
      case (directed_plan[i].kind)
        STEP_CFG: begin
          wait_drained();
          write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_data);
        end
        STEP_PIX: begin
          send_item(directed_plan[i].pix, directed_plan[i].pad, directed_plan[i].known,
                    directed_plan[i].want);
        end
        default: flush_frame();
      endcase
    end

    // Random phases of small frames. Some phases run with no idling on one
    // or both sides; the first one uses a frame large enough to fill the
    // block and holds the result side off while the pixel side keeps
    // offering back to back.
    random_base = items_sent;
    phase_idx = 0;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      w_pick = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(9, 40))
                                           : DIM_W'($urandom_range(0, 8));
      h_pick = DIM_W'($urandom_range(0, 6));
      if (phase_idx == 0) begin
        in_gap_max = 0;
        hold_output = 1'b1;
        w_pick = DIM_W'(8);
        h_pick = DIM_W'(6);
      end
      configure(w_pick, h_pick, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      repeat ($urandom_range(1, 3)) run_frame(1'b1);
      flush_frame();
      phase_idx++;
    end

    // Everything predicted must have arrived; the settling time also
    // catches any stray result after the last one.
    wait_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
